[rtl/touch_key_scanner_top_macros.svh]
// ----------------------------------------------------------------------------
// Touch key scanner assertion macros
// Clocked property shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef TOUCH_KEY_SCANNER_TOP_MACROS_SVH
`define TOUCH_KEY_SCANNER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define TKS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tks_pkg.sv]
// ----------------------------------------------------------------------------
// Touch key scanner package
// Field widths, item layout, register codes and control structs.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int RAW_W   = 22;
  localparam int CFG_W   = 22;
  localparam int FREQ_W  = 16;
  localparam int KEY_W   = 2;
  localparam int INT_W   = 12;
  localparam int IDX_W   = 3;
  localparam int MAX_PADS = 4;

  localparam int IN_W         = 96;
  localparam int PAD_VALID_LSB = MAX_PADS * RAW_W;
  localparam int BUTTON_BIT   = PAD_VALID_LSB + MAX_PADS;
  localparam int OUT_USED     = 1 + KEY_W + INT_W + 1 + FREQ_W + 1;
  localparam int OUT_W        = 40;

  localparam int DIG_W        = 7;
  localparam int REM_W        = 3;
  localparam int DN_W         = DIG_W + REM_W;
  localparam int RECIP5       = 205;
  localparam int RECIP5_SHIFT = 10;
  localparam int DPROD_W      = DN_W + 8;

  localparam int BASE_DIV     = 100;

  localparam int DIV_W        = INT_W + CFG_W;
  localparam int DIV_STEPS    = INT_W / 2;
  localparam int DCNT_W       = 3;
  localparam logic [INT_W-1:0] INT_MAX = 12'd4095;

  localparam logic [CFG_W-1:0]  TRIGGER_RST = 22'd50000;
  localparam logic [CFG_W-1:0]  RELEASE_RST = 22'd20000;
  localparam logic [CFG_W-1:0]  SPAN_RST    = 22'd100000;
  localparam logic [FREQ_W-1:0] FREQ0_RST   = 16'd261;
  localparam logic [FREQ_W-1:0] FREQ1_RST   = 16'd329;
  localparam logic [FREQ_W-1:0] FREQ2_RST   = 16'd392;
  localparam logic [FREQ_W-1:0] FREQ3_RST   = 16'd523;

  typedef enum logic [IDX_W-1:0] {
    REG_TRIGGER = 3'd0,
    REG_RELEASE = 3'd1,
    REG_SPAN    = 3'd2,
    REG_FREQ0   = 3'd3,
    REG_FREQ1   = 3'd4,
    REG_FREQ2   = 3'd5,
    REG_FREQ3   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic start;
    logic cal_load;
    logic adapt_go;
  } lane_ctrl_t;

  typedef struct packed {
    logic active;
    logic done;
  } merge_stat_t;

endpackage

[rtl/tks_lane.sv]
// ----------------------------------------------------------------------------
// Touch key scanner pad lane
// Smoothing, delta to baseline and baseline tracking for one pad.
// ----------------------------------------------------------------------------
module tks_lane #(
  parameter int COUNT_BITS = 22,
  parameter int FRAC_BITS  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tks_pkg::lane_ctrl_t         ctrl,
  input  logic [tks_pkg::RAW_W-1:0]   raw,
  input  logic                        pad_valid,
  input  logic                        adapt,
  output logic                        act,
  output logic [COUNT_BITS-1:0]       delta,
  output logic                        done
);

  localparam int SM_W   = COUNT_BITS + FRAC_BITS;
  localparam int SUM_W  = SM_W + 3;
  localparam int DIGITS = (SUM_W + tks_pkg::DIG_W - 1) / tks_pkg::DIG_W;
  localparam int PAD_W  = DIGITS * tks_pkg::DIG_W;
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam int PROD_W = 2 * COUNT_BITS;
  localparam logic [63:0] RECIP100_FULL = (64'd1 << COUNT_BITS) / 64'(tks_pkg::BASE_DIV);
  localparam logic [COUNT_BITS-1:0] RECIP100 = RECIP100_FULL[COUNT_BITS-1:0];

  logic [SM_W-1:0]                  smoothed;
  logic [COUNT_BITS-1:0]            baseline;
  logic [COUNT_BITS-1:0]            raw_q;
  logic [PAD_W-1:0]                 num;
  logic [PAD_W-1:0]                 quo;
  logic [tks_pkg::REM_W-1:0]        rem;
  logic [CNT_W-1:0]                 cnt;
  logic                             fin;
  logic                             ad_en;
  logic                             ad_neg;
  logic [COUNT_BITS-1:0]            ad_x;
  logic [COUNT_BITS-1:0]            ad_q0;

  logic [COUNT_BITS-1:0]            raw_m;
  logic [SM_W-1:0]                  raw_fx;
  logic [SUM_W-1:0]                 sum;
  logic [tks_pkg::DIG_W-1:0]        digit;
  logic [tks_pkg::DN_W-1:0]         dn;
  logic [tks_pkg::DPROD_W-1:0]      dprod;
  logic [tks_pkg::DIG_W-1:0]        qd;
  logic [tks_pkg::DN_W-1:0]         dr;
  logic [SM_W-1:0]                  sm_new;
  logic [SM_W-1:0]                  base_fx;
  logic [SM_W-1:0]                  diff;
  logic [COUNT_BITS-1:0]            ax;
  logic [PROD_W-1:0]                aprod;
  logic [COUNT_BITS-1:0]            a100;
  logic [COUNT_BITS-1:0]            ar;
  logic                             acorr;
  logic [COUNT_BITS-1:0]            aq;
  logic [COUNT_BITS-1:0]            ar2;
  logic [COUNT_BITS-1:0]            baseline_next;

  assign raw_m  = COUNT_BITS'(raw);
  assign raw_fx = {raw_m, {FRAC_BITS{1'b0}}};
  assign sum    = (SUM_W'(smoothed) << 1) + SUM_W'(raw_fx) + (SUM_W'(raw_fx) << 1)
                + SUM_W'(2);

  // divide by five, one seven-bit digit per cycle
  assign digit = num[PAD_W-1 -: tks_pkg::DIG_W];
  assign dn    = {rem, digit};
  assign dprod = tks_pkg::DPROD_W'(dn) * tks_pkg::DPROD_W'(tks_pkg::RECIP5);
  assign qd    = dprod[tks_pkg::RECIP5_SHIFT +: tks_pkg::DIG_W];
  assign dr    = dn - (tks_pkg::DN_W'(qd) << 2) - tks_pkg::DN_W'(qd);

  assign sm_new  = quo[SM_W-1:0];
  assign base_fx = {baseline, {FRAC_BITS{1'b0}}};
  assign diff    = (sm_new >= base_fx) ? (sm_new - base_fx) : (base_fx - sm_new);

  // baseline moves by floor((raw - base) / 100)
  assign ax    = (raw_q >= baseline) ? (raw_q - baseline) : (baseline - raw_q);
  assign aprod = PROD_W'(ax) * PROD_W'(RECIP100);
  assign a100  = ad_q0 * COUNT_BITS'(tks_pkg::BASE_DIV);
  assign ar    = ad_x - a100;
  assign acorr = (ar >= COUNT_BITS'(tks_pkg::BASE_DIV));
  assign aq    = ad_q0 + COUNT_BITS'(acorr);
  assign ar2   = acorr ? (ar - COUNT_BITS'(tks_pkg::BASE_DIV)) : ar;
  assign baseline_next = ad_neg ? (baseline - aq - COUNT_BITS'(ar2 != '0))
                                : (baseline + aq);

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      baseline <= '0;
      cnt      <= '0;
      fin      <= 1'b0;
      done     <= 1'b0;
      ad_en    <= 1'b0;
      act      <= 1'b0;
    end else begin
      done  <= fin;
      fin   <= (cnt == CNT_W'(1));
      ad_en <= ctrl.adapt_go && adapt;
      if (ctrl.start) begin
        act <= pad_valid;
        cnt <= CNT_W'(DIGITS);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (ctrl.cal_load && pad_valid) begin
        baseline <= raw_m;
        smoothed <= raw_fx;
      end
      if (fin && act) begin
        smoothed <= sm_new;
      end
      if (ad_en) begin
        baseline <= baseline_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      raw_q <= raw_m;
      num   <= PAD_W'(sum);
      rem   <= '0;
    end else if (cnt != '0) begin
      num <= num << tks_pkg::DIG_W;
      quo <= {quo[PAD_W-tks_pkg::DIG_W-1:0], qd};
      rem <= dr[tks_pkg::REM_W-1:0];
    end
    if (fin) begin
      delta <= diff[SM_W-1:FRAC_BITS];
    end
    if (ctrl.adapt_go) begin
      ad_x   <= ax;
      ad_neg <= (raw_q < baseline);
      ad_q0  <= aprod[PROD_W-1:COUNT_BITS];
    end
  end

endmodule

[rtl/tks_merge.sv]
// ----------------------------------------------------------------------------
// Touch key scanner merge stage
// Picks the strongest touched pad and scales its delta to an intensity.
// ----------------------------------------------------------------------------
module tks_merge #(
  parameter int NUM_KEYS   = 4,
  parameter int COUNT_BITS = 22
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   select,
  input  logic [NUM_KEYS-1:0]                    act,
  input  logic [NUM_KEYS-1:0][COUNT_BITS-1:0]    deltas,
  input  logic [tks_pkg::CFG_W-1:0]              trigger_threshold,
  input  logic [tks_pkg::CFG_W-1:0]              release_threshold,
  input  logic [tks_pkg::CFG_W-1:0]              intensity_span,
  output logic [NUM_KEYS-1:0]                    adapt,
  output tks_pkg::merge_stat_t                   stat,
  output logic [tks_pkg::KEY_W-1:0]              key,
  output logic [tks_pkg::INT_W-1:0]              intensity
);

  localparam int CMP_W = (COUNT_BITS > tks_pkg::CFG_W) ? COUNT_BITS : tks_pkg::CFG_W;

  logic                               active;
  logic                               sat;
  logic                               done;
  logic [tks_pkg::DCNT_W-1:0]         dcnt;
  logic [tks_pkg::DIV_W-1:0]          rem;
  logic [tks_pkg::DIV_W-1:0]          dvs;
  logic [tks_pkg::INT_W-1:0]          quo;

  logic [COUNT_BITS-1:0]              best;
  logic [tks_pkg::KEY_W-1:0]          best_key;
  logic                               any;
  logic                               win;
  logic [NUM_KEYS-1:0]                adapt_next;
  logic [COUNT_BITS-1:0]              range;
  logic                               sat_c;
  logic [tks_pkg::CFG_W-1:0]          rng;
  logic [tks_pkg::DIV_W-1:0]          dividend;
  logic                               ge1;
  logic                               ge0;
  logic [tks_pkg::DIV_W-1:0]          r1;
  logic [tks_pkg::DIV_W-1:0]          dvs_h;
  logic [tks_pkg::DIV_W-1:0]          r0;

  always_comb begin
    best       = '0;
    best_key   = '0;
    any        = 1'b0;
    win        = 1'b0;
    adapt_next = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      win = act[i] && (CMP_W'(deltas[i]) > CMP_W'(trigger_threshold)) && (deltas[i] > best);
      if (win) begin
        best     = deltas[i];
        best_key = tks_pkg::KEY_W'(i);
        any      = 1'b1;
      end
      adapt_next[i] = act[i] && !win
                    && (CMP_W'(deltas[i]) < CMP_W'(release_threshold));
    end
  end

  assign range    = best - COUNT_BITS'(trigger_threshold);
  assign sat_c    = (intensity_span == '0) || (CMP_W'(range) >= CMP_W'(intensity_span));
  assign rng      = tks_pkg::CFG_W'(range);
  assign dividend = (tks_pkg::DIV_W'(rng) << tks_pkg::INT_W) - tks_pkg::DIV_W'(rng);

  // two quotient bits per cycle against a right-shifting divisor
  assign ge1   = (rem >= dvs);
  assign r1    = ge1 ? (rem - dvs) : rem;
  assign dvs_h = dvs >> 1;
  assign ge0   = (r1 >= dvs_h);
  assign r0    = ge0 ? (r1 - dvs_h) : r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      dcnt   <= '0;
      done   <= 1'b0;
    end else begin
      done <= (dcnt == tks_pkg::DCNT_W'(1));
      if (select) begin
        active <= any;
        dcnt   <= tks_pkg::DCNT_W'(tks_pkg::DIV_STEPS);
      end else if (dcnt != '0) begin
        dcnt <= dcnt - tks_pkg::DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (select) begin
      key   <= best_key;
      adapt <= adapt_next;
      sat   <= any && sat_c;
      rem   <= any ? dividend : '0;
      dvs   <= tks_pkg::DIV_W'(intensity_span) << (tks_pkg::INT_W - 1);
    end else if (dcnt != '0) begin
      rem <= r0;
      dvs <= dvs >> 2;
      quo <= {quo[tks_pkg::INT_W-3:0], ge1, ge0};
    end
  end

  assign intensity   = active ? (sat ? tks_pkg::INT_MAX : quo) : '0;
  assign stat.active = active;
  assign stat.done   = done;

endmodule

[rtl/touch_key_scanner_top.sv]
// ----------------------------------------------------------------------------
// Touch key scanner
// Baseline-tracking capacitive touch keys with intensity, tone and mute.
// ----------------------------------------------------------------------------
// From a scan frame's acceptance to the next frame's acceptance, each pad
// lane divides its smoothing sum by five one seven-bit digit per cycle, then
// the merge stage runs its intensity divider, two quotient bits per cycle,
// while the lanes update their baselines. A calibrate frame is absorbed in
// the cycle it is accepted and yields no result item. A finished result is
// loaded into the output register once that register is free; until then
// the scanner holds the result and accepts no new frame.
module touch_key_scanner_top #(
  parameter int NUM_KEYS   = 4,
  parameter int COUNT_BITS = 22,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // raw_key0, raw_key1, raw_key2, raw_key3, pad_valid, button_level
  input  logic [tks_pkg::IN_W-1:0]     s_axis_tdata,
  // calibrate
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // touch_active, key_index, intensity, tone_on, tone_freq, muted
  output logic [tks_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tks_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tks_pkg::CFG_W-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SMOOTH = 5'b00010,
    ST_ADAPT  = 5'b00100,
    ST_WAIT   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t                               state;
  state_t                               state_next;
  logic [tks_pkg::CFG_W-1:0]            trigger_threshold;
  logic [tks_pkg::CFG_W-1:0]            release_threshold;
  logic [tks_pkg::CFG_W-1:0]            intensity_span;
  logic [3:0][tks_pkg::FREQ_W-1:0]      tone_freq_key;
  logic                                 mute_flag;
  logic                                 last_button;

  logic                                 in_fire;
  logic                                 calibrate;
  logic                                 button_level;
  logic                                 select;
  logic                                 out_load;
  logic                                 slot_free;
  tks_pkg::lane_ctrl_t                  lane_ctrl;
  logic [NUM_KEYS-1:0]                  lane_act;
  logic [NUM_KEYS-1:0]                  lane_done;
  logic [NUM_KEYS-1:0][COUNT_BITS-1:0]  lane_delta;
  logic [NUM_KEYS-1:0]                  adapt;
  tks_pkg::merge_stat_t                 mstat;
  logic [tks_pkg::KEY_W-1:0]            key;
  logic [tks_pkg::INT_W-1:0]            intensity;
  logic                                 tone_on;
  logic [tks_pkg::FREQ_W-1:0]           tone_freq;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign calibrate     = s_axis_tuser;
  assign button_level  = s_axis_tdata[tks_pkg::BUTTON_BIT];
  assign slot_free     = !m_axis_tvalid || m_axis_tready;

  assign lane_ctrl.start    = in_fire && !calibrate;
  assign lane_ctrl.cal_load = in_fire && calibrate;
  assign lane_ctrl.adapt_go = (state == ST_ADAPT);

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    tks_lane #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (lane_ctrl),
      .raw       (s_axis_tdata[k*tks_pkg::RAW_W +: tks_pkg::RAW_W]),
      .pad_valid (s_axis_tdata[tks_pkg::PAD_VALID_LSB + k]),
      .adapt     (adapt[k]),
      .act       (lane_act[k]),
      .delta     (lane_delta[k]),
      .done      (lane_done[k])
    );
  end

  tks_merge #(
    .NUM_KEYS   (NUM_KEYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_merge (
    .clk               (clk),
    .rst               (rst),
    .select            (select),
    .act               (lane_act),
    .deltas            (lane_delta),
    .trigger_threshold (trigger_threshold),
    .release_threshold (release_threshold),
    .intensity_span    (intensity_span),
    .adapt             (adapt),
    .stat              (mstat),
    .key               (key),
    .intensity         (intensity)
  );

  always_comb begin
    state_next = state;
    select     = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire && !calibrate) begin
          state_next = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        if (&lane_done) begin
          select     = 1'b1;
          state_next = ST_ADAPT;
        end
      end
      ST_ADAPT: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (mstat.done) begin
          if (slot_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign tone_on   = mstat.active && !mute_flag;
  assign tone_freq = tone_on ? tone_freq_key[key] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      m_axis_tvalid     <= 1'b0;
      mute_flag         <= 1'b0;
      last_button       <= 1'b1;
      trigger_threshold <= tks_pkg::TRIGGER_RST;
      release_threshold <= tks_pkg::RELEASE_RST;
      intensity_span    <= tks_pkg::SPAN_RST;
      tone_freq_key[0]  <= tks_pkg::FREQ0_RST;
      tone_freq_key[1]  <= tks_pkg::FREQ1_RST;
      tone_freq_key[2]  <= tks_pkg::FREQ2_RST;
      tone_freq_key[3]  <= tks_pkg::FREQ3_RST;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_fire && !calibrate) begin
        if (!button_level && last_button) begin
          mute_flag <= !mute_flag;
        end
        last_button <= button_level;
      end
      if (cfg_valid && cfg_ready) begin
        case (tks_pkg::cfg_reg_t'(cfg_index))
          tks_pkg::REG_TRIGGER: trigger_threshold <= cfg_data;
          tks_pkg::REG_RELEASE: release_threshold <= cfg_data;
          tks_pkg::REG_SPAN:    intensity_span    <= cfg_data;
          tks_pkg::REG_FREQ0:   tone_freq_key[0]  <= cfg_data[tks_pkg::FREQ_W-1:0];
          tks_pkg::REG_FREQ1:   tone_freq_key[1]  <= cfg_data[tks_pkg::FREQ_W-1:0];
          tks_pkg::REG_FREQ2:   tone_freq_key[2]  <= cfg_data[tks_pkg::FREQ_W-1:0];
          tks_pkg::REG_FREQ3:   tone_freq_key[3]  <= cfg_data[tks_pkg::FREQ_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {{(tks_pkg::OUT_W - tks_pkg::OUT_USED){1'b0}},
                       mute_flag, tone_freq, tone_on, intensity, key, mstat.active};
    end
  end

endmodule

[rtl/tks_checker.sv]
// ----------------------------------------------------------------------------
// Touch key scanner port checker
// Temporal checks on the stream ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "touch_key_scanner_top_macros.svh"

module tks_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [tks_pkg::IN_W-1:0]     s_axis_tdata,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [tks_pkg::OUT_W-1:0]    m_axis_tdata,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [tks_pkg::IDX_W-1:0]    cfg_index,
  input logic [tks_pkg::CFG_W-1:0]    cfg_data
);

  `TKS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result item changed while stalled")
  `TKS_ASSERT_SAME(a_tone_rule, m_axis_tvalid, m_axis_tdata[15] == (m_axis_tdata[0] && !m_axis_tdata[32]), "tone_on disagrees with touch and mute")
  `TKS_ASSERT_SAME(a_idle_zero, m_axis_tvalid && !m_axis_tdata[15], m_axis_tdata[31:16] == 16'd0 && (m_axis_tdata[0] || m_axis_tdata[14:1] == 14'd0), "silent or untouched result carries nonzero fields")
  `TKS_ASSERT_NEXT(a_cal_silent, s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid, !m_axis_tvalid, "calibrate item produced a result")
  `TKS_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !s_axis_tready, "scan item accepted while previous one in flight")

endmodule

bind touch_key_scanner_top tks_checker u_tks_checker (.*);
